/* rtl/lae_pkg.sv */
package lae_pkg;

    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int ROW_W    = 12;
    localparam int CFG_W    = 13;
    localparam int FW_W     = 11;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);
    localparam int MAX_HEIGHT = 4096;
    localparam logic [CH_W-1:0] PIX_MAX = 8'd255;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic shift;
        logic emit;
        logic edge_on;
        logic last;
    } t_ctl;

    typedef struct packed {
        t_ctl ctl;
        t_pix pix;
        t_pix top;
        t_pix mid;
    } t_entry;

endpackage

/* rtl/laplacian_edge_3x3_unit.sv */
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_req_type, i_red_in, i_green_in, i_blue_in
// output  | o_valid | i_stall | o_red_out, o_green_out, o_blue_out, o_frame_end
// config  | i_cfg_we| -       | i_cfg_idx, i_cfg_data
//
// One item per clock sustained while no stall holds the flow; a result leaves through
// the line store read register, the queue and the output register.
// The 4-entry queue between front and back sets how far the front runs ahead
// of a stalled output.
// Synchronous active-low reset clears control and window; line stores are not cleared.
module laplacian_edge_3x3_unit import lae_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_req_type,
    input  logic [CH_W-1:0]  i_red_in,
    input  logic [CH_W-1:0]  i_green_in,
    input  logic [CH_W-1:0]  i_blue_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CH_W-1:0]  o_red_out,
    output logic [CH_W-1:0]  o_green_out,
    output logic [CH_W-1:0]  o_blue_out,
    output logic             o_frame_end
);

    logic            push, pop, q_valid;
    t_entry          push_entry, q_entry;
    logic [Q_CW-1:0] q_count;

    lae_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_pix      ({i_red_in, i_green_in, i_blue_in}),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    lae_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    lae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out),
        .o_frame_end (o_frame_end)
    );

endmodule

/* rtl/lae_front.sv */
module lae_front import lae_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_req_type,
    input  t_pix             i_pix,
    input  logic [Q_CW-1:0]  i_q_count,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEF_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam logic [CW-1:0] DEF_COL_LAST = CW'(DEF_W - 1);
    localparam logic [ROW_W-1:0] DEF_ROW_LAST = ROW_W'(480 - 1);

    logic [2*PIX_W-1:0] r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;

    logic [CW-1:0]    r_col_last, n_col_last;
    logic [ROW_W-1:0] r_row_last, n_row_last;
    logic [CW-1:0]    r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic             r_done, n_done;

    logic             r_s2_valid;
    t_ctl             r_s2_ctl, n_ctl;
    t_pix             r_s2_pix;
    logic [CW-1:0]    r_s2_addr;

    logic             acc, take_pix, take_drain, produce, in_last, border, out_last;
    logic [FW_W-1:0]  wv;
    logic [CFG_W-1:0] hv;

    assign o_stall = ((Q_CW+1)'(i_q_count) + (Q_CW+1)'(r_s2_valid)) >= (Q_CW+1)'(Q_DEPTH);
    assign acc        = i_valid && !o_stall;
    assign take_pix   = acc && (i_req_type == REQ_PIXEL) && !r_done;
    assign take_drain = acc && (i_req_type == REQ_DRAIN) && r_done;

    assign produce  = (r_in_row >= ROW_W'(2)) || (r_in_row == ROW_W'(1) && r_in_col != '0);
    assign in_last  = (r_in_row >= r_row_last) && (r_in_col >= r_col_last);
    assign border   = (r_out_row == '0) || (r_out_row >= r_row_last) ||
                      (r_out_col == '0) || (r_out_col >= r_col_last);
    assign out_last = (r_out_row >= r_row_last) && (r_out_col >= r_col_last);

    assign wv = i_cfg_data[FW_W-1:0];
    assign hv = i_cfg_data;

    always_comb begin
        n_col_last = r_col_last;
        n_row_last = r_row_last;
        if (i_cfg_we && i_cfg_idx == REG_FRAME_WIDTH) begin
            if (wv < FW_W'(3)) begin
                n_col_last = CW'(2);
            end else if (int'(wv) > MAX_WIDTH) begin
                n_col_last = CW'(MAX_WIDTH - 1);
            end else begin
                n_col_last = CW'(wv - FW_W'(1));
            end
        end
        if (i_cfg_we && i_cfg_idx == REG_FRAME_HEIGHT) begin
            if (hv < CFG_W'(3)) begin
                n_row_last = ROW_W'(2);
            end else if (int'(hv) > MAX_HEIGHT) begin
                n_row_last = ROW_W'(MAX_HEIGHT - 1);
            end else begin
                n_row_last = ROW_W'(hv - CFG_W'(1));
            end
        end
    end

    always_comb begin
        n_ctl.shift   = take_pix;
        n_ctl.emit    = take_drain || (take_pix && produce);
        n_ctl.edge_on = take_pix && !border;
        n_ctl.last    = out_last;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_done    = r_done;
        if (i_cfg_we) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_done    = 1'b0;
        end else begin
            if (take_pix) begin
                if (in_last) begin
                    n_done = 1'b1;
                end else if (r_in_col >= r_col_last) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
            end
            if (n_ctl.emit) begin
                if (out_last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_done    = 1'b0;
                end else if (r_out_col >= r_col_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= DEF_COL_LAST;
            r_row_last <= DEF_ROW_LAST;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_done     <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_col_last <= n_col_last;
            r_row_last <= n_row_last;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_done     <= n_done;
            r_s2_valid <= take_pix || take_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctl  <= n_ctl;
        r_s2_pix  <= i_pix;
        r_s2_addr <= r_in_col;
    end

    // line store: read on a pixel accept, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (take_pix) begin
            r_rd <= r_line[r_in_col];
        end
        if (r_s2_valid && r_s2_ctl.shift) begin
            r_line[r_s2_addr] <= {r_rd[PIX_W-1:0], r_s2_pix};
        end
    end

    assign o_push        = r_s2_valid;
    assign o_entry.ctl   = r_s2_ctl;
    assign o_entry.pix   = r_s2_pix;
    assign o_entry.top   = r_rd[2*PIX_W-1:PIX_W];
    assign o_entry.mid   = r_rd[PIX_W-1:0];

endmodule

/* rtl/lae_fifo.sv */
module lae_fifo import lae_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_entry          i_entry,
    input  logic            i_pop,
    output logic            o_valid,
    output t_entry          o_entry,
    output logic [Q_CW-1:0] o_count
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;
    logic            do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* rtl/lae_back.sv */
module lae_back import lae_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_entry          i_q_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue,
    output logic            o_frame_end
);

    typedef logic [8:0][PIX_W-1:0] t_win;

    function automatic logic [CH_W-1:0] f_edge(input t_win w, input int unsigned sh);
        logic [10:0]        sum;
        logic signed [11:0] acc;
        logic [CH_W-1:0]    c;
        c   = w[4][sh +: CH_W];
        sum = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                sum = sum + 11'(w[i][sh +: CH_W]);
            end
        end
        acc = $signed({1'b0, c, 3'b000}) - $signed({1'b0, sum});
        if (acc < 0) begin
            return '0;
        end else if (acc > $signed({4'b0000, PIX_MAX})) begin
            return PIX_MAX;
        end else begin
            return acc[CH_W-1:0];
        end
    endfunction

    t_win r_win, n_win;
    logic r_valid;
    logic take;

    assign take  = i_q_valid && (!i_q_entry.ctl.emit || !r_valid || !i_stall);
    assign o_pop = take;

    always_comb begin
        n_win = r_win;
        if (i_q_entry.ctl.shift) begin
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = i_q_entry.top;
            n_win[3] = r_win[4];
            n_win[4] = r_win[5];
            n_win[5] = i_q_entry.mid;
            n_win[6] = r_win[7];
            n_win[7] = r_win[8];
            n_win[8] = i_q_entry.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take && i_q_entry.ctl.shift) begin
                r_win <= n_win;
            end
            if (take && i_q_entry.ctl.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_entry.ctl.emit) begin
            o_red       <= i_q_entry.ctl.edge_on ? f_edge(n_win, 16) : '0;
            o_green     <= i_q_entry.ctl.edge_on ? f_edge(n_win, 8)  : '0;
            o_blue      <= i_q_entry.ctl.edge_on ? f_edge(n_win, 0)  : '0;
            o_frame_end <= i_q_entry.ctl.last;
        end
    end

    assign o_valid = r_valid;

endmodule

/* rtl/lae_chk.sv */
module lae_chk import lae_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_req_type,
    input logic [CH_W-1:0]  i_red_in,
    input logic [CH_W-1:0]  i_green_in,
    input logic [CH_W-1:0]  i_blue_in,
    input logic             o_valid,
    input logic             i_stall,
    input logic [CH_W-1:0]  o_red_out,
    input logic [CH_W-1:0]  o_green_out,
    input logic [CH_W-1:0]  o_blue_out,
    input logic             o_frame_end
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_end_on_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_red_out == '0 && o_green_out == '0 && o_blue_out == '0)
        else $error("last pixel of frame not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_out) && $stable(o_green_out) &&
            $stable(o_blue_out) && $stable(o_frame_end))
        else $error("stalled output changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_req_type) && $stable(i_red_in) &&
            $stable(i_green_in) && $stable(i_blue_in))
        else $error("stalled input changed");

endmodule

bind laplacian_edge_3x3_unit lae_chk u_chk (.*);
